/* rtl/rsas_pkg.sv */
// Shared types, constants and command codes for the rotated sorted array search block.
`timescale 1ns / 1ps

package rsas_pkg;

  // Default store depth and fixed field widths.
  localparam int MAX_LEN_DEF = 1024;
  localparam int VAL_W       = 32;
  localparam int POS_W       = 10;

  // Operation carried by an input beat.
  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_APPEND = 2'd1,
    MODE_SEARCH = 2'd2
  } mode_t;

  typedef struct packed {
    mode_t                    mode;
    logic signed [VAL_W-1:0]  value;
  } rsas_in_t;

  typedef struct packed {
    logic              found;
    logic [POS_W-1:0]  position;
  } rsas_out_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_PIV,
    S_PLAST,
    S_PVAL,
    S_LAST,
    S_SEEK
  } state_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR,
    DP_APPEND,
    DP_LOAD,
    DP_FIRST,
    DP_PIV_STEP,
    DP_PLAST,
    DP_PVAL,
    DP_SEL_LEFT,
    DP_SEL_RIGHT,
    DP_SEEK_STEP
  } dp_op_t;

  // Kind of result produced when the controller emits one.
  typedef enum logic [1:0] {
    RES_MISS,
    RES_SINGLE,
    RES_HIT
  } res_kind_t;

  typedef struct packed {
    dp_op_t     op;
    logic       emit;
    res_kind_t  kind;
  } dp_cmd_t;

  typedef struct packed {
    logic cnt_zero;
    logic cnt_one;
    logic piv_done;
    logic in_left;
    logic in_right;
    logic seek_hit;
    logic seek_done;
  } dp_stat_t;

endpackage

/* rtl/rsas_ctrl.sv */
// Sequencing state machine for clear, append and the two-phase binary search.
`timescale 1ns / 1ps

module rsas_ctrl
  import rsas_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  mode_t    in_mode,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;

  assign busy = (state_r != S_IDLE);

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start && in_mode == MODE_SEARCH) begin
          state_nxt = S_FIRST;
        end
      end
      S_FIRST: begin
        if (stat.cnt_zero || stat.cnt_one) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_PIV;
        end
      end
      S_PIV: begin
        if (stat.piv_done) begin
          state_nxt = S_PLAST;
        end
      end
      S_PLAST: state_nxt = S_PVAL;
      S_PVAL:  state_nxt = S_LAST;
      S_LAST: begin
        if (stat.in_left || stat.in_right) begin
          state_nxt = S_SEEK;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SEEK: begin
        if (stat.seek_hit || stat.seek_done) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Command outputs to the datapath.
  always_comb begin
    cmd = '{op: DP_NOP, emit: 1'b0, kind: RES_MISS};
    case (state_r)
      S_IDLE: begin
        if (start) begin
          case (in_mode)
            MODE_CLEAR:  cmd.op = DP_CLEAR;
            MODE_APPEND: cmd.op = DP_APPEND;
            MODE_SEARCH: cmd.op = DP_LOAD;
            default:     cmd.op = DP_NOP;
          endcase
        end
      end
      S_FIRST: begin
        if (stat.cnt_zero) begin
          cmd.emit = 1'b1;
          cmd.kind = RES_MISS;
        end else if (stat.cnt_one) begin
          cmd.emit = 1'b1;
          cmd.kind = RES_SINGLE;
        end else begin
          cmd.op = DP_FIRST;
        end
      end
      S_PIV:   cmd.op = DP_PIV_STEP;
      S_PLAST: cmd.op = DP_PLAST;
      S_PVAL:  cmd.op = DP_PVAL;
      S_LAST: begin
        if (stat.in_left) begin
          cmd.op = DP_SEL_LEFT;
        end else if (stat.in_right) begin
          cmd.op = DP_SEL_RIGHT;
        end else begin
          cmd.emit = 1'b1;
          cmd.kind = RES_MISS;
        end
      end
      S_SEEK: begin
        cmd.op = DP_SEEK_STEP;
        if (stat.seek_hit) begin
          cmd.emit = 1'b1;
          cmd.kind = RES_HIT;
        end else if (stat.seek_done) begin
          cmd.emit = 1'b1;
          cmd.kind = RES_MISS;
        end
      end
      default: cmd.op = DP_NOP;
    endcase
  end

  // An accepted search always makes the block busy on the next cycle.
  a_search_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode == MODE_SEARCH) |=> busy)
    else $error("search beat did not start the sequencer");

  // A result is only ever produced from inside a search.
  a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> busy)
    else $error("result emitted while idle");

  // With no beat offered the idle controller leaves the datapath alone.
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (!busy && !start) |-> (cmd.op == DP_NOP && !cmd.emit))
    else $error("idle controller issued a command");

endmodule

/* rtl/rsas_dpath.sv */
// Element store, search bounds, probe comparators and result register.
`timescale 1ns / 1ps

module rsas_dpath
  import rsas_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  rsas_in_t  in_item,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_strobe,
  output rsas_out_t out_item
);

  localparam int AW = $clog2(MAX_LEN);
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int SW = CW + 2;
  localparam int PW = (AW > POS_W) ? AW : POS_W;

  logic signed [VAL_W-1:0] mem [MAX_LEN];
  logic signed [VAL_W-1:0] rd_data_r;
  logic [AW-1:0]           rd_addr;
  logic signed [SW-1:0]    addr_s;

  logic [CW-1:0]           count_r, count_nxt;
  logic signed [SW-1:0]    lo_r, lo_nxt, hi_r, hi_nxt;
  logic signed [VAL_W-1:0] tgt_r, tgt_nxt, first_r, first_nxt;
  logic signed [VAL_W-1:0] plast_r, plast_nxt, pval_r, pval_nxt;

  logic signed [SW-1:0]    cnt_s, last_idx, sum, mid;
  logic signed [SW-1:0]    piv_lo, piv_hi, sk_lo, sk_hi, step_lo, step_hi, step_sum, step_mid;
  logic                    probe_ge, probe_eq, probe_gt, can_append;
  logic [PW-1:0]           mid_pos;

  logic                    out_strobe_r, out_strobe_nxt;
  rsas_out_t               out_item_r, out_item_nxt;

  // Midpoint of two signed indices, rounded down.
  function automatic logic signed [SW-1:0] sum_right(input logic signed [SW-1:0] a,
                                                     input logic signed [SW-1:0] b);
    logic signed [SW-1:0] s;
    s = a + b;
    return s >>> 1;
  endfunction

  // Current probe index and stored element count as signed indices.
  assign cnt_s    = signed'(SW'(count_r));
  assign last_idx = cnt_s - SW'(1);
  assign sum      = lo_r + hi_r;
  assign mid      = sum >>> 1;
  assign mid_pos  = PW'(mid[AW-1:0]);

  // Probe comparisons against the first element and the target.
  assign probe_ge = (rd_data_r >= first_r);
  assign probe_eq = (rd_data_r == tgt_r);
  assign probe_gt = (rd_data_r > tgt_r);

  // Bound updates for one pivot probe and one seek probe.
  assign piv_lo   = probe_ge ? (mid + SW'(1)) : lo_r;
  assign piv_hi   = probe_ge ? hi_r : mid;
  assign sk_lo    = probe_gt ? lo_r : (mid + SW'(1));
  assign sk_hi    = probe_gt ? (mid - SW'(1)) : hi_r;
  assign step_lo  = (cmd.op == DP_SEEK_STEP) ? sk_lo : piv_lo;
  assign step_hi  = (cmd.op == DP_SEEK_STEP) ? sk_hi : piv_hi;
  assign step_sum = step_lo + step_hi;
  assign step_mid = step_sum >>> 1;

  assign can_append = (count_r < CW'(MAX_LEN));

  // Status back to the controller.
  always_comb begin
    stat.cnt_zero  = (count_r == '0);
    stat.cnt_one   = (count_r == CW'(1));
    stat.piv_done  = (piv_lo >= piv_hi);
    stat.in_left   = (first_r <= tgt_r) && (tgt_r <= plast_r);
    stat.in_right  = (pval_r <= tgt_r) && (tgt_r <= rd_data_r);
    stat.seek_hit  = probe_eq;
    stat.seek_done = (sk_hi < sk_lo);
  end

  // Read address for the next probe, chosen by the current operation.
  always_comb begin
    case (cmd.op)
      DP_FIRST:     addr_s = last_idx >>> 1;
      DP_PIV_STEP:  addr_s = stat.piv_done ? (piv_lo - SW'(1)) : step_mid;
      DP_PLAST:     addr_s = lo_r;
      DP_PVAL:      addr_s = last_idx;
      DP_SEL_LEFT:  addr_s = (lo_r - SW'(1)) >>> 1;
      DP_SEL_RIGHT: addr_s = sum_right(lo_r, last_idx);
      DP_SEEK_STEP: addr_s = step_mid;
      default:      addr_s = '0;
    endcase
  end

  assign rd_addr = addr_s[AW-1:0];

  // Element store: one write port for appends, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.op == DP_APPEND && can_append) begin
      mem[count_r[AW-1:0]] <= in_item.value;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Next values of the count, bounds and latched elements.
  always_comb begin
    count_nxt = count_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    tgt_nxt   = tgt_r;
    first_nxt = first_r;
    plast_nxt = plast_r;
    pval_nxt  = pval_r;
    case (cmd.op)
      DP_CLEAR:  count_nxt = '0;
      DP_APPEND: begin
        if (can_append) begin
          count_nxt = count_r + CW'(1);
        end
      end
      DP_LOAD:   tgt_nxt = in_item.value;
      DP_FIRST: begin
        first_nxt = rd_data_r;
        lo_nxt    = '0;
        hi_nxt    = last_idx;
      end
      DP_PIV_STEP: begin
        lo_nxt = piv_lo;
        hi_nxt = piv_hi;
      end
      DP_PLAST:  plast_nxt = rd_data_r;
      DP_PVAL:   pval_nxt  = rd_data_r;
      DP_SEL_LEFT: begin
        lo_nxt = '0;
        hi_nxt = lo_r - SW'(1);
      end
      DP_SEL_RIGHT: hi_nxt = last_idx;
      DP_SEEK_STEP: begin
        lo_nxt = sk_lo;
        hi_nxt = sk_hi;
      end
      default: count_nxt = count_r;
    endcase
  end

  // Result beat formed from the emit request.
  always_comb begin
    out_strobe_nxt = cmd.emit;
    out_item_nxt   = '0;
    case (cmd.kind)
      RES_SINGLE: out_item_nxt.found = probe_eq;
      RES_HIT: begin
        out_item_nxt.found    = 1'b1;
        out_item_nxt.position = mid_pos[POS_W-1:0];
      end
      default: out_item_nxt = '0;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      count_r      <= count_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    tgt_r      <= tgt_nxt;
    first_r    <= first_nxt;
    plast_r    <= plast_nxt;
    pval_r     <= pval_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // The element count never passes the store depth.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_LEN))
    else $error("element count beyond capacity");

  // Every emit request turns into a result beat on the next cycle.
  a_emit_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> out_strobe)
    else $error("emit request lost");

endmodule

/* rtl/rotated_sorted_array_search.sv */
// Timing: clear and append take effect at the accepting edge; busy stays low for them.
// Search: reads the first element, probes for the pivot, reads the elements on each side of it and
// the last one, picks a half, then probes it; the result beat is registered from the final step.
// Throughput: clear and append every cycle while idle; a new beat is taken in the cycle the
// result shows, so a search holds the input until its result. The receiver cannot stall results.
// Reset (rst_n low, synchronous) empties the store and idles the sequencer; contents stay.
`timescale 1ns / 1ps

module rotated_sorted_array_search
  import rsas_pkg::*;
#(
  parameter int MAX_LEN = MAX_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  rsas_in_t  in_item,
  output logic      busy,
  output logic      out_strobe,
  output rsas_out_t out_item
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // Sequencer.
  rsas_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_item.mode),
    .stat    (stat),
    .busy    (busy),
    .cmd     (cmd)
  );

  // Store and search datapath.
  rsas_dpath #(
    .MAX_LEN (MAX_LEN)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  // A miss always reports position zero.
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_item.found) |-> (out_item.position == '0))
    else $error("miss reported with a non-zero position");

endmodule
